// ===== rtl/core/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and codes for the open-addressed hash table
// Request and result payloads, operation and status codes, and the probe
// token and hit report that travel between the controller and the slot cells.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 8;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int OSLOT_W = 4;
  // Wide enough for any slot number and probe count the table supports.
  localparam int SLOT_W  = 6;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   value_out;
    logic [OSLOT_W-1:0] slot;
  } out_t;

  typedef struct packed {
    logic              live;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] left;
  } tok_t;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
  } res_t;

endpackage

// ===== rtl/core/open_addressing_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top: linear-probing hash table of SLOTS entries
// A sequencer and a ring of slot cells; a probe token walks the ring.
// ----------------------------------------------------------------------------
// Usage: a request (kind, key, value) enters on in_valid/in_ready and one
// result (status, value_out, slot) leaves on out_valid/out_ready for each
// request. Kind insert places the key in the first free slot from its home
// slot, lookup returns the first matching entry in probe order, and delete
// returns and frees it. One request is in flight at a time.
// Hashing: the home slot is hashed one key character at a time through the
// shared multiply and reduce path, in the states S_MUL, S_DIV and S_RED. The
// probe token then walks 1 to SLOTS cells, one cell per cycle, and the next
// request is taken only after the result has been written to the output
// register. The unused kind skips the probe.
// Reset clears all occupancy bits at once, so the table starts empty, and
// in_ready is high as soon as the state register has been reset.
// A stalled receiver holds the finished result in the output register; the
// next request is still taken and hashed, and waits for the register to
// empty before its own result is written.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top
  import oaht_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int KEY_BYTES = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  tok_t              inj_tok;
  logic [SLOT_W-1:0] inj_home;
  tok_t              tok   [SLOTS];
  res_t              res   [SLOTS];
  logic [SLOTS-1:0]  live_vec;
  logic [SLOTS-1:0]  hit_vec;

  oaht_ctrl #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .inj_tok   (inj_tok),
    .inj_home  (inj_home),
    .res_i     (res)
  );

  // Each cell takes the token from its lower neighbor; the last cell wraps
  // around to the first so a probe can run past the top slot.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    oaht_cell #(
      .SLOT_ID (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .inj_tok  (inj_tok),
      .inj_home (inj_home),
      .prev_tok (tok[(i + SLOTS - 1) % SLOTS]),
      .tok_o    (tok[i]),
      .res_o    (res[i])
    );
    assign live_vec[i] = tok[i].live;
    assign hit_vec[i]  = res[i].hit;
  end

  // At most one probe token is ever alive in the ring.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(live_vec))
    else $error("more than one probe token in the cell ring");

  // Only the cell holding the token may report a hit.
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one cell reported a hit");

  // A new request is taken only after the previous token has died.
  a_idle_ring: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (live_vec == '0))
    else $error("request accepted while a probe token is still alive");

endmodule

// ===== rtl/core/oaht_cell.sv =====
// ----------------------------------------------------------------------------
// oaht_cell: one slot of the hash table
// Holds one entry and examines the probe token passing through it. A token
// that finds its target here acts on the entry and stops; otherwise it moves
// on to the next cell unless it has no cells left to visit.
// ----------------------------------------------------------------------------
module oaht_cell
  import oaht_pkg::*;
#(
  parameter int SLOT_ID = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tok_t              inj_tok,
  input  logic [SLOT_W-1:0] inj_home,
  input  tok_t              prev_tok,
  output tok_t              tok_o,
  output res_t              res_o
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  tok_t             tok_r, tok_nxt;
  res_t             res_r, res_nxt;
  tok_t             tok_in;
  logic             hit;

  always_comb begin
    tok_in = prev_tok;
    if (inj_tok.live && (inj_home == SLOT_W'(SLOT_ID))) begin
      tok_in = inj_tok;
    end

    hit = 1'b0;
    if (tok_in.live) begin
      if (tok_in.kind == KIND_INSERT) begin
        hit = !valid_r;
      end else if (tok_in.kind == KIND_LOOKUP || tok_in.kind == KIND_DELETE) begin
        hit = valid_r && (key_r == tok_in.key);
      end
    end

    valid_nxt = valid_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    if (hit && tok_in.kind == KIND_INSERT) begin
      valid_nxt = 1'b1;
      key_nxt   = tok_in.key;
      val_nxt   = tok_in.value;
    end else if (hit && tok_in.kind == KIND_DELETE) begin
      valid_nxt = 1'b0;
    end

    tok_nxt      = tok_in;
    tok_nxt.live = tok_in.live && !hit && (tok_in.left != '0);
    tok_nxt.left = tok_in.left - 1'b1;

    res_nxt.hit   = hit;
    res_nxt.value = (hit && tok_in.kind != KIND_INSERT) ? val_r : '0;
    res_nxt.slot  = hit ? SLOT_W'(SLOT_ID) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
      res_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign tok_o = tok_r;
  assign res_o = res_r;

endmodule

// ===== rtl/core/oaht_ctrl.sv =====
// ----------------------------------------------------------------------------
// oaht_ctrl: request sequencer for the hash table
// Takes a request, trims the key, computes the home slot one character at a
// time, launches the probe token into the cell row and collects the result.
// ----------------------------------------------------------------------------
module oaht_ctrl
  import oaht_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int KEY_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  output tok_t              inj_tok,
  output logic [SLOT_W-1:0] inj_home,
  input  res_t              res_i [SLOTS]
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int K_SH  = 17;
  // Floor reciprocal: the quotient estimate is exact or one short.
  localparam int RECIP = (1 << K_SH) / SLOTS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RED   = 3'd3;
  localparam logic [2:0] S_INJ   = 3'd4;
  localparam logic [2:0] S_PROBE = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [IDX_W-1:0]  h_r, h_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic [16:0]       p_r, p_nxt;
  logic [16:0]       q_r, q_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  out_t              rslt_r, rslt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic [KEY_W-1:0]  nk;
  logic              run;
  logic [7:0]        c;
  logic              hash_end;
  logic [8:0]        hc;
  logic [16:0]       p_calc;
  logic [33:0]       prod;
  logic [33:0]       qs;
  logic [16:0]       r;
  logic [16:0]       r_adj;
  logic              any_hit;
  logic [VAL_W-1:0]  hit_val;
  logic [SLOT_W-1:0] hit_slot;

  // The key ends at its first zero byte or after KEY_BYTES characters.
  always_comb begin
    nk  = '0;
    run = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i < KEY_BYTES && run && in_data.key[8*i +: 8] != 8'd0) begin
        nk[8*i +: 8] = in_data.key[8*i +: 8];
      end else begin
        run = 1'b0;
      end
    end
  end

  // Hash step h = ((h + c) * c) mod SLOTS in three steps:
  // product, reciprocal quotient, then remainder with one correction.
  assign c        = key_r[8*idx_r[2:0] +: 8];
  assign hash_end = idx_r[3] || (c == 8'd0);
  assign hc       = 9'(h_r) + 9'(c);
  assign p_calc   = 17'(hc) * 17'(c);
  assign prod     = 34'(p_r) * 34'(RECIP);
  assign qs       = 34'(q_r) * 34'(SLOTS);
  assign r        = p_r - qs[16:0];
  assign r_adj    = (r >= 17'(SLOTS)) ? (r - 17'(SLOTS)) : r;

  // Only the cell holding the token can report a hit in a given cycle.
  always_comb begin
    any_hit  = 1'b0;
    hit_val  = '0;
    hit_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (res_i[i].hit) begin
        any_hit  = 1'b1;
        hit_val  = hit_val | res_i[i].value;
        hit_slot = hit_slot | res_i[i].slot;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    h_nxt         = h_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    rslt_nxt      = rslt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_data.kind;
          key_nxt   = nk;
          value_nxt = in_data.value;
          h_nxt     = '0;
          idx_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (hash_end) begin
          if (kind_r inside {KIND_INSERT, KIND_LOOKUP, KIND_DELETE}) begin
            state_nxt = S_INJ;
          end else begin
            rslt_nxt  = '{status: STAT_MISS, value_out: '0, slot: '0};
            state_nxt = S_FIN;
          end
        end else begin
          p_nxt     = p_calc;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        q_nxt     = prod[33:17];
        state_nxt = S_RED;
      end
      S_RED: begin
        h_nxt     = r_adj[IDX_W-1:0];
        idx_nxt   = idx_r + 4'd1;
        state_nxt = S_MUL;
      end
      S_INJ: begin
        cnt_nxt   = '0;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (any_hit) begin
          rslt_nxt  = '{status: STAT_OK, value_out: hit_val, slot: hit_slot[OSLOT_W-1:0]};
          state_nxt = S_FIN;
        end else if (cnt_r == IDX_W'(SLOTS - 1)) begin
          rslt_nxt.status    = (kind_r == KIND_INSERT) ? STAT_FULL : STAT_MISS;
          rslt_nxt.value_out = '0;
          rslt_nxt.slot      = '0;
          state_nxt          = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = rslt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    key_r   <= key_nxt;
    value_r <= value_nxt;
    h_r     <= h_nxt;
    idx_r   <= idx_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    rslt_r  <= rslt_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    inj_tok.live  = (state_r == S_INJ);
    inj_tok.kind  = kind_r;
    inj_tok.key   = key_r;
    inj_tok.value = value_r;
    inj_tok.left  = SLOT_W'(SLOTS - 1);
  end

  assign inj_home  = SLOT_W'(h_r);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the linear-probing hash table
// Requests go through a valid/ready handshake. A predictor written in this
// bench keeps its own shadow copy of the table and works out each result.
// A checker compares every result field by field with the oldest pending
// prediction. The tests cover directed corner cases first: empty table,
// key termination, and filling to overflow. Random pool-based traffic
// follows, with idling on both sides, one long output stall, and a final
// full-rate phase.
// ----------------------------------------------------------------------------
module tb_top;
  import oaht_pkg::*;

  localparam int SLOTS          = 16;
  localparam int KEY_BYTES      = 8;
  // Kind 3 has no name in the package; the table must answer it as a miss.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int POOL_SIZE      = 20;
  localparam int HOLD_CYCLES    = 300;
  // The watchdog limit lies well above both the longest request and the long
  // output stall, so that many quiet cycles can only mean the table has hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  open_addressing_hash_table_top #(
    .SLOTS    (SLOTS),
    .KEY_BYTES(KEY_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the table, updated as each request is accepted.
  logic [KEY_W-1:0] shadow_key  [SLOTS];
  logic [VAL_W-1:0] shadow_value[SLOTS];
  logic             shadow_used [SLOTS];

  // Results that the table still owes, oldest first.
  out_t pending_results[$];

  // Keys that random traffic reuses so that lookups and deletes find hits.
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int               key_len [POOL_SIZE];

  int  fail_count  = 0;
  int  n_requests  = 0;
  int  n_placed    = 0;
  int  n_full      = 0;
  int  n_found     = 0;
  int  n_missed    = 0;
  int  quiet_count = 0;
  bit  gaps_on     = 1'b0;
  bit  stalls_on   = 1'b0;
  bit  hold_ask    = 1'b0;

  // ---------------------------------------------------------------- predictor

  // A key ends at its first zero byte or after KEY_BYTES characters.
  function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'h00) break;
      k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

  // Add-then-multiply running hash of the characters, reduced each step.
  function automatic int unsigned home_slot(input logic [KEY_W-1:0] k);
    int unsigned h;
    int unsigned c;
    h = 0;
    for (int i = 0; i < 8; i++) begin
      c = k[8*i +: 8];
      if (c == 0) break;
      h = ((h + c) * c) % SLOTS;
    end
    return h;
  endfunction

  function automatic int occupancy();
    int n;
    n = 0;
    for (int s = 0; s < SLOTS; s++) n += shadow_used[s];
    return n;
  endfunction

  // Applies one request to the shadow table and returns the result it owes.
  function automatic out_t apply_request(input in_t req);
    logic [KEY_W-1:0] k;
    int unsigned      home;
    int unsigned      s;
    out_t             res;
    k             = trim_key(req.key);
    home          = home_slot(k);
    res.status    = STAT_MISS;
    res.value_out = '0;
    res.slot      = '0;
    case (req.kind)
      KIND_INSERT: begin
        res.status = STAT_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          s = (home + i) % SLOTS;
          if (!shadow_used[s]) begin
            shadow_used[s]  = 1'b1;
            shadow_key[s]   = k;
            shadow_value[s] = req.value;
            res.status      = STAT_OK;
            res.slot        = OSLOT_W'(s);
            break;
          end
        end
      end
      KIND_LOOKUP, KIND_DELETE: begin
        // Empty slots do not end the search, so a miss scans the whole ring.
        for (int i = 0; i < SLOTS; i++) begin
          s = (home + i) % SLOTS;
          if (shadow_used[s] && shadow_key[s] == k) begin
            res.status    = STAT_OK;
            res.value_out = shadow_value[s];
            res.slot      = OSLOT_W'(s);
            if (req.kind == KIND_DELETE) begin
              shadow_used[s]  = 1'b0;
              shadow_key[s]   = '0;
              shadow_value[s] = '0;
            end
            break;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------ sender

  // Offers one request, waits for the handshake and records its prediction.
  // It is entered and left on a rising edge, so in_valid stays high between
  // back-to-back requests without being lowered in between.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    in_t  req;
    out_t res;
    int   gap;
    req.kind  = kind;
    req.key   = key;
    req.value = value;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    res = apply_request(req);
    pending_results.push_back(res);
    n_requests++;
    if (kind == KIND_INSERT && res.status == STAT_OK) n_placed++;
    if (res.status == STAT_FULL) n_full++;
    if (kind != KIND_INSERT && res.status == STAT_OK) n_found++;
    if (res.status == STAT_MISS) n_missed++;
  endtask

  function automatic logic [KEY_W-1:0] random_key(input int len);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Fills the bytes past the terminating zero with junk the table must ignore.
  function automatic logic [KEY_W-1:0] add_tail(input logic [KEY_W-1:0] k,
                                                input int len);
    logic [KEY_W-1:0] raw;
    raw = k;
    for (int b = len + 1; b < 8; b++) raw[8*b +: 8] = 8'($urandom_range(0, 255));
    return raw;
  endfunction

  // ------------------------------------------------------------------- tests

  // On an empty table every lookup and delete misses, as does the unused kind.
  task automatic test_empty_table();
    send_request(KIND_LOOKUP, 64'h0000_0000_0063_6261, 8'h11);
    send_request(KIND_DELETE, 64'h0000_0000_0000_0000, 8'h22);
    send_request(KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
  endtask

  // Key termination: an empty key is legal and hashes to slot 0, bytes after
  // the first zero are ignored, and a full eight-character key is compared
  // over all of its bytes.
  task automatic test_key_forms();
    send_request(KIND_INSERT, 64'h0000_0000_0000_0000, 8'hFF);
    send_request(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 8'h00);
    send_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    send_request(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8'hAA);
    send_request(KIND_INSERT, 64'h5A5A_5A5A_5A00_0041, 8'h5A);
    send_request(KIND_DELETE, 64'h0000_0000_0000_0041, 8'h00);
    send_request(KIND_DELETE, 64'h0000_0000_0000_0041, 8'h00);
  endtask

  // Inserts until every slot is taken, then one more must report full.
  task automatic test_fill_to_full();
    int len;
    while (occupancy() < SLOTS) begin
      len = $urandom_range(1, 8);
      send_request(KIND_INSERT, random_key(len), 8'($urandom_range(0, 255)));
    end
    send_request(KIND_INSERT, random_key(3), 8'h77);
  endtask

  // Random traffic over a small key pool. Inserts are held back when the
  // table is nearly full so that it keeps moving between sparse and packed.
  task automatic run_traffic(input int count);
    int               pick;
    int               idx;
    int               insert_cut;
    logic [KEY_W-1:0] raw;
    logic [KIND_W-1:0] op;
    for (int n = 0; n < count; n++) begin
      idx = $urandom_range(0, POOL_SIZE - 1);
      raw = key_pool[idx];
      if ($urandom_range(0, 3) == 0) raw = add_tail(raw, key_len[idx]);
      // Now and then a key nobody stored, to exercise full-ring misses.
      if ($urandom_range(0, 9) == 0) raw = {$urandom, $urandom};
      insert_cut = (occupancy() >= SLOTS - 2) ? 30 : 50;
      pick = $urandom_range(0, 99);
      if (pick < 4) op = KIND_UNUSED;
      else if (pick < insert_cut) op = KIND_INSERT;
      else if (pick < 72) op = KIND_LOOKUP;
      else op = KIND_DELETE;
      send_request(op, raw, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_mixed_traffic();
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_len[i]  = $urandom_range(0, 8);
      key_pool[i] = random_key(key_len[i]);
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_traffic(330);
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // held result backs up into the table and in_ready drops.
  task automatic test_output_hold();
    gaps_on  = 1'b0;
    hold_ask = 1'b1;
    run_traffic(10);
  endtask

  // Closing phase with no idling on either side.
  task automatic test_full_rate();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_traffic(185);
  endtask

  // ---------------------------------------------------------------- receiver

  // Drives out_ready: a long counted hold when asked, random stall bursts
  // while stalls are enabled, otherwise always ready.
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ask = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- checker

  // Every result leaving the table is matched against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending request: status %0d value_out %0d slot %0d",
               out_data.status, out_data.value_out, out_data.slot);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, out_data.value_out);
          fail_count++;
        end
        if (out_data.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  // Ends the run if neither channel moves a request for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("tb: timeout after %0d quiet cycles", quiet_count);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      shadow_used[s]  = 1'b0;
      shadow_key[s]   = '0;
      shadow_value[s] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_key_forms();
    test_fill_to_full();
    test_mixed_traffic();
    test_output_hold();
    test_full_rate();
    in_valid <= 1'b0;

    // Wait for every owed result, then give the table time to show any
    // stray extra result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d requests checked, %0d inserts placed, %0d refused as full",
             n_requests, n_placed, n_full);
    $display("tb: %0d lookups or deletes found their key, %0d requests missed",
             n_found, n_missed);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
